@@ hdl/mdbfp_pkg.sv @@
// ----------------------------------------------------------------------------
// mdbfp_pkg
// Types and constants shared by the best-frame picker and its interfaces.
// ----------------------------------------------------------------------------
package mdbfp_pkg;

	localparam int SUBCHAN_MAX = 8;
	localparam int SLICER_MAX  = 8;
	localparam int HANDLE_BITS = 12;

	localparam int SC_W     = $clog2(SUBCHAN_MAX);
	localparam int SL_W     = $clog2(SLICER_MAX);
	localparam int SLOT_W   = SC_W + SL_W;
	localparam int NSLOTS   = SUBCHAN_MAX * SLICER_MAX;
	localparam int LIN_W    = $clog2(NSLOTS);
	localparam int NB_W     = $clog2(NSLOTS + 1);
	localparam int AGE_W    = 12;
	localparam int SCORE_W  = 18;
	localparam int CFG_IDX_W = 2;

	localparam logic [AGE_W-1:0] AGE_MAX = {AGE_W{1'b1}};

	localparam logic [CFG_IDX_W-1:0] REG_NUM_SUBCHAN   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_NUM_SLICERS   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HOLD_TICKS    = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_RETRY_CEILING = 2'd3;

	localparam logic [1:0] RES_PASS    = 2'd0;
	localparam logic [1:0] RES_WINNER  = 2'd1;
	localparam logic [1:0] RES_RELEASE = 2'd2;

	localparam logic KIND_TICK  = 1'b0;
	localparam logic KIND_FRAME = 1'b1;

	localparam logic [1:0] FEC_PLAIN = 2'd0;

	typedef struct packed {
		logic                   kind;
		logic                   fx25_busy;
		logic [2:0]             subchan_index;
		logic [2:0]             slice_index;
		logic [HANDLE_BITS-1:0] frame_handle;
		logic [15:0]            frame_crc;
		logic [23:0]            audio_level;
		logic [5:0]             correction_count;
		logic [1:0]             fec_kind;
	} item_t;

	typedef struct packed {
		logic [1:0]             result_kind;
		logic [2:0]             out_subchan;
		logic [2:0]             out_slice;
		logic [HANDLE_BITS-1:0] out_handle;
		logic [23:0]            out_level;
		logic [5:0]             out_corrections;
		logic [1:0]             out_fec_kind;
		logic [63:0]            discard_mask;
	} result_t;

	typedef struct packed {
		logic [HANDLE_BITS-1:0] handle;
		logic [23:0]            level;
		logic [5:0]             corrections;
		logic [1:0]             fec;
	} slot_t;

	typedef struct packed {
		logic [3:0]       ns;
		logic [3:0]       nl;
		logic [NB_W-1:0]  nb;
		logic [11:0]      hold;
		logic [3:0]       ceiling;
	} cfg_t;

endpackage

@@ hdl/mdbfp_if.sv @@
// ----------------------------------------------------------------------------
// mdbfp interfaces
// Valid/ready channels for input items, results and register writes.
// ----------------------------------------------------------------------------
interface mdbfp_item_if;
	import mdbfp_pkg::*;
	logic  valid;
	logic  ready;
	item_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface mdbfp_result_if;
	import mdbfp_pkg::*;
	logic    valid;
	logic    ready;
	result_t payload;
	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

interface mdbfp_cfg_if;
	import mdbfp_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [31:0]          wdata;
	modport source (output valid, output index, output wdata, input ready);
	modport sink (input valid, input index, input wdata, output ready);
endinterface

@@ hdl/mdbfp_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// mdbfp_cfg_regs
// Configuration registers and the effective grid dimensions derived from them.
// ----------------------------------------------------------------------------
module mdbfp_cfg_regs (
	input  logic             clk,
	input  logic             arst_n,
	mdbfp_cfg_if.sink        cfg,
	output mdbfp_pkg::cfg_t  regs
);
	import mdbfp_pkg::*;

	logic [3:0]  num_subchan_q;
	logic [3:0]  num_slicers_q;
	logic [11:0] hold_ticks_q;
	logic [3:0]  retry_ceiling_q;
	logic [3:0]  ns;
	logic [3:0]  nl;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_subchan_q   <= 4'd1;
			num_slicers_q   <= 4'd1;
			hold_ticks_q    <= 12'd480;
			retry_ceiling_q <= 4'd5;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_NUM_SUBCHAN:   num_subchan_q   <= cfg.wdata[3:0];
				REG_NUM_SLICERS:   num_slicers_q   <= cfg.wdata[3:0];
				REG_HOLD_TICKS:    hold_ticks_q    <= cfg.wdata[11:0];
				REG_RETRY_CEILING: retry_ceiling_q <= cfg.wdata[3:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		ns = num_subchan_q;
		if (num_subchan_q == 4'd0) ns = 4'd1;
		else if (num_subchan_q > 4'(SUBCHAN_MAX)) ns = 4'(SUBCHAN_MAX);
		nl = num_slicers_q;
		if (num_slicers_q == 4'd0) nl = 4'd1;
		else if (num_slicers_q > 4'(SLICER_MAX)) nl = 4'(SLICER_MAX);
	end

	assign regs.ns      = ns;
	assign regs.nl      = nl;
	assign regs.nb      = NB_W'(ns) * NB_W'(nl);
	assign regs.hold    = hold_ticks_q;
	assign regs.ceiling = retry_ceiling_q;

endmodule

@@ hdl/multi_decoder_best_frame_picker.sv @@
// ----------------------------------------------------------------------------
// multi_decoder_best_frame_picker
// Collects frames from a grid of decoder slots for one channel and forwards
// the best one once the oldest candidate has waited long enough.
//
// The items channel carries sample ticks and frame arrivals; the results
// channel returns at most one result per item; cfg writes the four registers
// and must only be used while the block is idle. An item is taken when the
// block is idle, even while a result still waits in the output register.
// A tick walks every slot of the grid and reads and rewrites the age of each
// occupied slot through the age memory. A selection scores each occupied
// slot against every slot of the grid through the CRC memory's second read
// port.
// Reset clears the occupancy flags and loads the register defaults; the
// memories need no clearing. When the receiver stalls, the block holds its
// finished result and waits before producing the next one.
// ----------------------------------------------------------------------------
module multi_decoder_best_frame_picker (
	input  logic        clk,
	input  logic        arst_n,
	mdbfp_item_if.sink  items,
	mdbfp_result_if.source results,
	mdbfp_cfg_if.sink   cfg
);
	import mdbfp_pkg::*;

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_DEC    = 4'd1;
	localparam logic [3:0] S_ARR    = 4'd2;
	localparam logic [3:0] S_T_RD   = 4'd3;
	localparam logic [3:0] S_T_WR   = 4'd4;
	localparam logic [3:0] S_N_RD   = 4'd5;
	localparam logic [3:0] S_N_LAT  = 4'd6;
	localparam logic [3:0] S_M_SCAN = 4'd7;
	localparam logic [3:0] S_B_RD   = 4'd8;
	localparam logic [3:0] S_B_OUT  = 4'd9;

	cfg_t regs;

	mdbfp_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	slot_t       pay_mem [NSLOTS];
	logic [15:0] crc_mem [NSLOTS];
	logic [AGE_W-1:0] age_mem [NSLOTS];

	logic [3:0]        state_q;
	item_t             it_q;
	result_t           out_q;
	logic              out_valid_q;
	logic [NSLOTS-1:0] full_q;
	logic              was_full_q;

	logic [SC_W-1:0] sub_q, n_sub_q, m_sub_q, b_sub_q;
	logic [SL_W-1:0] sli_q, n_sli_q, m_sli_q, b_sli_q;
	logic [LIN_W-1:0] n_lin_q, m_lin_q, b_lin_q;
	logic              m_done_q, b_valid_q;
	logic              p_v_s1, p_full_s1;
	logic [LIN_W-1:0]  p_lin_s1;
	logic signed [SCORE_W-1:0] score_q, best_q;
	logic [15:0]       crc_n_q;
	logic [63:0]       mask_q;

	slot_t             pay_rd_q;
	logic [15:0]       crc_a_rd_q, crc_b_rd_q;
	logic [AGE_W-1:0]  age_rd_q;

	logic [SC_W-1:0] ns_m1;
	logic [SL_W-1:0] nl_m1;
	logic            out_free, out_load, pass, outgrid;
	logic [SLOT_W-1:0] arr_addr, t_addr, n_addr, m_addr, b_addr;
	logic            pay_re, pay_we, crc_b_re, age_re, age_we;
	logic [SLOT_W-1:0] pay_addr, age_addr;
	logic [AGE_W-1:0]  age_wd, age_inc;
	slot_t           pay_wd;
	logic            t_last, n_last, m_last;
	logic [LIN_W-1:0] lin_gap;
	logic [NB_W-1:0]  bonus;
	logic signed [SCORE_W-1:0] base;

	assign ns_m1    = SC_W'(regs.ns - 4'd1);
	assign nl_m1    = SL_W'(regs.nl - 4'd1);
	assign out_free = !out_valid_q || results.ready;
	assign pass     = (regs.ns == 4'd1) && (regs.nl == 4'd1) && !it_q.fx25_busy;
	assign outgrid  = ({1'b0, it_q.subchan_index} >= regs.ns)
		|| ({1'b0, it_q.slice_index} >= regs.nl);
	assign out_load = out_free && (((state_q == S_DEC) && (it_q.kind == KIND_FRAME)
		&& (pass || outgrid)) || ((state_q == S_ARR) && was_full_q)
		|| (state_q == S_B_OUT));
	assign arr_addr = {SC_W'(it_q.subchan_index), SL_W'(it_q.slice_index)};
	assign t_addr   = {sub_q, sli_q};
	assign n_addr   = {n_sub_q, n_sli_q};
	assign m_addr   = {m_sub_q, m_sli_q};
	assign b_addr   = {b_sub_q, b_sli_q};
	assign t_last   = (sub_q == ns_m1) && (sli_q == nl_m1);
	assign n_last   = (n_sub_q == ns_m1) && (n_sli_q == nl_m1);
	assign m_last   = (m_sub_q == ns_m1) && (m_sli_q == nl_m1);
	assign age_inc  = (age_rd_q == AGE_MAX) ? AGE_MAX : age_rd_q + AGE_W'(1);
	assign lin_gap  = (p_lin_s1 > n_lin_q) ? p_lin_s1 - n_lin_q : n_lin_q - p_lin_s1;
	assign bonus    = regs.nb + NB_W'(1) - NB_W'(lin_gap);

	assign items.ready     = (state_q == S_IDLE);
	assign results.valid   = out_valid_q;
	assign results.payload = out_q;

	always_comb begin
		if (pay_rd_q.fec != FEC_PLAIN)
			base = SCORE_W'(9000) - SCORE_W'(100 * pay_rd_q.corrections);
		else
			base = (SCORE_W'($signed({1'b0, regs.ceiling}))
				- SCORE_W'($signed({1'b0, pay_rd_q.corrections}))) * SCORE_W'(1000)
				+ SCORE_W'(1);
	end

	always_comb begin
		pay_re   = 1'b0;
		pay_we   = 1'b0;
		pay_addr = arr_addr;
		pay_wd   = '{handle: it_q.frame_handle, level: it_q.audio_level,
			corrections: it_q.correction_count, fec: it_q.fec_kind};
		crc_b_re = 1'b0;
		age_re   = 1'b0;
		age_we   = 1'b0;
		age_addr = t_addr;
		age_wd   = '0;
		unique case (state_q)
			S_DEC: begin
				if (it_q.kind == KIND_FRAME && !pass && !outgrid) begin
					pay_re   = 1'b1;
					pay_we   = 1'b1;
					age_we   = 1'b1;
					age_addr = arr_addr;
				end
			end
			S_T_RD: age_re = full_q[t_addr];
			S_T_WR: begin
				if (age_inc > regs.hold) begin
					age_we = it_q.fx25_busy;
				end else begin
					age_we = 1'b1;
					age_wd = age_inc;
				end
			end
			S_N_RD: begin
				pay_re   = full_q[n_addr];
				pay_addr = n_addr;
			end
			S_M_SCAN: crc_b_re = !m_done_q;
			S_B_RD: begin
				pay_re   = 1'b1;
				pay_addr = b_addr;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (pay_re) begin
			pay_rd_q   <= pay_mem[pay_addr];
			crc_a_rd_q <= crc_mem[pay_addr];
		end
		if (pay_we) begin
			pay_mem[pay_addr] <= pay_wd;
			crc_mem[pay_addr] <= it_q.frame_crc;
		end
		if (crc_b_re)
			crc_b_rd_q <= crc_mem[m_addr];
		if (age_re)
			age_rd_q <= age_mem[age_addr];
		if (age_we)
			age_mem[age_addr] <= age_wd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			full_q      <= '0;
			p_v_s1      <= 1'b0;
		end else begin
			if (out_load)
				out_valid_q <= 1'b1;
			else if (results.ready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (items.valid) begin
						it_q    <= items.payload;
						state_q <= S_DEC;
					end
				end
				S_DEC: begin
					if (it_q.kind == KIND_FRAME) begin
						if (pass || outgrid) begin
							if (out_free) begin
								out_q <= '{result_kind: pass ? RES_PASS : RES_RELEASE,
									out_subchan: it_q.subchan_index,
									out_slice: it_q.slice_index,
									out_handle: it_q.frame_handle,
									out_level: it_q.audio_level,
									out_corrections: it_q.correction_count,
									out_fec_kind: it_q.fec_kind,
									discard_mask: 64'd0};
								state_q     <= S_IDLE;
							end
						end else begin
							was_full_q       <= full_q[arr_addr];
							full_q[arr_addr] <= 1'b1;
							state_q          <= S_ARR;
						end
					end else begin
						sub_q   <= '0;
						sli_q   <= '0;
						state_q <= S_T_RD;
					end
				end
				S_ARR: begin
					if (!was_full_q) begin
						state_q <= S_IDLE;
					end else if (out_free) begin
						out_q <= '{result_kind: RES_RELEASE,
							out_subchan: it_q.subchan_index,
							out_slice: it_q.slice_index,
							out_handle: pay_rd_q.handle,
							out_level: pay_rd_q.level,
							out_corrections: pay_rd_q.corrections,
							out_fec_kind: pay_rd_q.fec,
							discard_mask: 64'd0};
						state_q     <= S_IDLE;
					end
				end
				S_T_RD: begin
					if (full_q[t_addr]) begin
						state_q <= S_T_WR;
					end else if (t_last) begin
						state_q <= S_IDLE;
					end else if (sli_q == nl_m1) begin
						sli_q <= '0;
						sub_q <= sub_q + SC_W'(1);
					end else begin
						sli_q <= sli_q + SL_W'(1);
					end
				end
				S_T_WR: begin
					if (age_inc > regs.hold && !it_q.fx25_busy) begin
						n_sub_q   <= '0;
						n_sli_q   <= '0;
						n_lin_q   <= '0;
						b_valid_q <= 1'b0;
						mask_q    <= '0;
						state_q   <= S_N_RD;
					end else if (t_last) begin
						state_q <= S_IDLE;
					end else begin
						state_q <= S_T_RD;
						if (sli_q == nl_m1) begin
							sli_q <= '0;
							sub_q <= sub_q + SC_W'(1);
						end else begin
							sli_q <= sli_q + SL_W'(1);
						end
					end
				end
				S_N_RD: begin
					if (full_q[n_addr]) begin
						mask_q[n_lin_q] <= 1'b1;
						state_q         <= S_N_LAT;
					end else if (n_last) begin
						state_q <= S_B_RD;
					end else begin
						n_lin_q <= n_lin_q + LIN_W'(1);
						if (n_sub_q == ns_m1) begin
							n_sub_q <= '0;
							n_sli_q <= n_sli_q + SL_W'(1);
						end else begin
							n_sub_q <= n_sub_q + SC_W'(1);
						end
					end
				end
				S_N_LAT: begin
					crc_n_q  <= crc_a_rd_q;
					score_q  <= base;
					m_sub_q  <= '0;
					m_sli_q  <= '0;
					m_lin_q  <= '0;
					m_done_q <= 1'b0;
					p_v_s1   <= 1'b0;
					state_q  <= S_M_SCAN;
				end
				S_M_SCAN: begin
					p_v_s1    <= !m_done_q;
					p_full_s1 <= full_q[m_addr];
					p_lin_s1  <= m_lin_q;
					if (!m_done_q) begin
						if (m_last) begin
							m_done_q <= 1'b1;
						end else begin
							m_lin_q <= m_lin_q + LIN_W'(1);
							if (m_sub_q == ns_m1) begin
								m_sub_q <= '0;
								m_sli_q <= m_sli_q + SL_W'(1);
							end else begin
								m_sub_q <= m_sub_q + SC_W'(1);
							end
						end
					end
					if (p_v_s1 && p_full_s1 && p_lin_s1 != n_lin_q && crc_b_rd_q == crc_n_q)
						score_q <= score_q + SCORE_W'(bonus);
					if (m_done_q && !p_v_s1) begin
						if (!b_valid_q || score_q > best_q) begin
							b_valid_q <= 1'b1;
							best_q    <= score_q;
							b_sub_q   <= n_sub_q;
							b_sli_q   <= n_sli_q;
							b_lin_q   <= n_lin_q;
						end
						if (n_last) begin
							state_q <= S_B_RD;
						end else begin
							state_q <= S_N_RD;
							n_lin_q <= n_lin_q + LIN_W'(1);
							if (n_sub_q == ns_m1) begin
								n_sub_q <= '0;
								n_sli_q <= n_sli_q + SL_W'(1);
							end else begin
								n_sub_q <= n_sub_q + SC_W'(1);
							end
						end
					end
				end
				S_B_RD: begin
					mask_q[b_lin_q] <= 1'b0;
					state_q         <= S_B_OUT;
				end
				S_B_OUT: begin
					if (out_free) begin
						out_q <= '{result_kind: RES_WINNER,
							out_subchan: 3'(b_sub_q),
							out_slice: 3'(b_sli_q),
							out_handle: pay_rd_q.handle,
							out_level: pay_rd_q.level,
							out_corrections: pay_rd_q.corrections,
							out_fec_kind: pay_rd_q.fec,
							discard_mask: mask_q};
						full_q      <= '0;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

@@ bench/multi_decoder_best_frame_picker_test.sv @@
// ----------------------------------------------------------------------------
// multi_decoder_best_frame_picker_test
// Drives ticks and frame arrivals through the picker under several register
// settings, predicts every result with its own slot table and compares each
// result transfer field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module multi_decoder_best_frame_picker_test;
	import mdbfp_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	bit failed = 1'b0;

	mdbfp_item_if   items ();
	mdbfp_result_if results ();
	mdbfp_cfg_if    cfg ();

	multi_decoder_best_frame_picker uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.items   (items),
		.results (results),
		.cfg     (cfg)
	);

	always #10 clk = ~clk;

	// Predictor state.
	bit [3:0]  reg_ns = 4'd1;
	bit [3:0]  reg_nl = 4'd1;
	bit [11:0] reg_hold = 12'd480;
	bit [3:0]  reg_ceiling = 4'd5;
	bit        full_q [NSLOTS];
	bit [11:0] age_q [NSLOTS];
	bit [15:0] crc_q [NSLOTS];
	slot_t     frame_q [NSLOTS];

	item_t   pending_items [$];
	result_t expected_results [$];
	int      wait_cycles [$];

	function automatic int clamp_count(bit [3:0] v, int maxv);
		if (v == 0)
			return 1;
		if (v > maxv)
			return maxv;
		return int'(v);
	endfunction

	function automatic result_t make_result(logic [1:0] k, int sc, int sl, slot_t f,
			logic [63:0] mask);
		result_t r;
		r.result_kind = k;
		r.out_subchan = sc[2:0];
		r.out_slice = sl[2:0];
		r.out_handle = f.handle;
		r.out_level = f.level;
		r.out_corrections = f.corrections;
		r.out_fec_kind = f.fec;
		r.discard_mask = mask;
		return r;
	endfunction

	function automatic result_t pick_best(int ns, int nl);
		int score [NSLOTS];
		int nb;
		int best;
		int s;
		int t;
		logic [63:0] mask;
		nb = ns * nl;
		best = -1;
		mask = '0;
		for (int n = 0; n < nb; n++) begin
			s = (n % ns) * SLICER_MAX + n / ns;
			score[n] = 0;
			if (full_q[s]) begin
				if (frame_q[s].fec != FEC_PLAIN)
					score[n] = 9000 - 100 * int'(frame_q[s].corrections);
				else
					score[n] = int'(reg_ceiling) * 1000
						- int'(frame_q[s].corrections) * 1000 + 1;
			end
		end
		for (int n = 0; n < nb; n++) begin
			s = (n % ns) * SLICER_MAX + n / ns;
			if (full_q[s]) begin
				for (int m = 0; m < nb; m++) begin
					t = (m % ns) * SLICER_MAX + m / ns;
					if (m != n && full_q[t] && crc_q[t] == crc_q[s])
						score[n] += nb + 1 - (m > n ? m - n : n - m);
				end
			end
		end
		for (int n = 0; n < nb; n++) begin
			s = (n % ns) * SLICER_MAX + n / ns;
			if (full_q[s] && (best < 0 || score[n] > score[best]))
				best = n;
		end
		if (best < 0)
			best = 0;
		for (int n = 0; n < nb; n++) begin
			s = (n % ns) * SLICER_MAX + n / ns;
			if (full_q[s] && n != best)
				mask[n] = 1'b1;
		end
		s = (best % ns) * SLICER_MAX + best / ns;
		for (int i = 0; i < NSLOTS; i++) begin
			full_q[i] = 1'b0;
			age_q[i] = '0;
		end
		return make_result(RES_WINNER, best % ns, best / ns, frame_q[s], mask);
	endfunction

	function automatic void predict_item(item_t it);
		int ns;
		int nl;
		int s;
		slot_t f;
		ns = clamp_count(reg_ns, SUBCHAN_MAX);
		nl = clamp_count(reg_nl, SLICER_MAX);
		f.handle = it.frame_handle;
		f.level = it.audio_level;
		f.corrections = it.correction_count;
		f.fec = it.fec_kind;
		if (it.kind == KIND_FRAME) begin
			if (ns == 1 && nl == 1 && !it.fx25_busy) begin
				expected_results.push_back(make_result(RES_PASS, int'(it.subchan_index),
					int'(it.slice_index), f, '0));
				return;
			end
			if (it.subchan_index >= ns || it.slice_index >= nl) begin
				expected_results.push_back(make_result(RES_RELEASE,
					int'(it.subchan_index), int'(it.slice_index), f, '0));
				return;
			end
			s = it.subchan_index * SLICER_MAX + it.slice_index;
			if (full_q[s])
				expected_results.push_back(make_result(RES_RELEASE,
					int'(it.subchan_index), int'(it.slice_index), frame_q[s], '0));
			full_q[s] = 1'b1;
			frame_q[s] = f;
			crc_q[s] = it.frame_crc;
			age_q[s] = '0;
			return;
		end
		for (int sc = 0; sc < ns; sc++) begin
			for (int sl = 0; sl < nl; sl++) begin
				s = sc * SLICER_MAX + sl;
				if (full_q[s]) begin
					if (age_q[s] != AGE_MAX)
						age_q[s]++;
					if (age_q[s] > reg_hold) begin
						if (it.fx25_busy)
							age_q[s] = '0;
						else begin
							expected_results.push_back(pick_best(ns, nl));
							return;
						end
					end
				end
			end
		end
	endfunction

	// Input transfers are seen at the rising edge.
	bit in_taken = 1'b0;
	bit out_taken = 1'b0;
	always @(posedge clk) begin
		if (arst_n && items.valid && items.ready) begin
			predict_item(items.payload);
			in_taken = 1'b1;
		end
	end

	// Driver: takes items from the pending queue with random gaps.
	int gap_left = 0;
	bit hold_off = 1'b0;
	always @(negedge clk) begin
		if (arst_n) begin
			if (in_taken) begin
				in_taken = 1'b0;
				items.valid <= 1'b0;
				gap_left = $urandom_range(0, 16);
				if ($urandom_range(0, 3) == 0)
					gap_left = 0;
			end else if (!items.valid && !hold_off && pending_items.size() > 0) begin
				if (gap_left > 0)
					gap_left--;
				else begin
					items.payload <= pending_items.pop_front();
					items.valid <= 1'b1;
				end
			end
		end
	end

	// Monitor and sink stalls.
	int stall_left = 0;
	always @(posedge clk) begin
		if (arst_n && results.valid && results.ready) begin
			out_taken = 1'b1;
			if (expected_results.size() == 0) begin
				$error("result transfer with no expected result");
				failed = 1'b1;
			end else begin
				result_t e;
				result_t a;
				e = expected_results.pop_front();
				a = results.payload;
				if (a.result_kind !== e.result_kind) begin
					$error("result_kind exp %0d got %0d", e.result_kind, a.result_kind);
					failed = 1'b1;
				end
				if (a.out_subchan !== e.out_subchan) begin
					$error("out_subchan exp %0d got %0d", e.out_subchan, a.out_subchan);
					failed = 1'b1;
				end
				if (a.out_slice !== e.out_slice) begin
					$error("out_slice exp %0d got %0d", e.out_slice, a.out_slice);
					failed = 1'b1;
				end
				if (a.out_handle !== e.out_handle) begin
					$error("out_handle exp %0h got %0h", e.out_handle, a.out_handle);
					failed = 1'b1;
				end
				if (a.out_level !== e.out_level) begin
					$error("out_level exp %0h got %0h", e.out_level, a.out_level);
					failed = 1'b1;
				end
				if (a.out_corrections !== e.out_corrections) begin
					$error("out_corrections exp %0d got %0d", e.out_corrections,
						a.out_corrections);
					failed = 1'b1;
				end
				if (a.out_fec_kind !== e.out_fec_kind) begin
					$error("out_fec_kind exp %0d got %0d", e.out_fec_kind, a.out_fec_kind);
					failed = 1'b1;
				end
				if (a.discard_mask !== e.discard_mask) begin
					$error("discard_mask exp %0h got %0h", e.discard_mask, a.discard_mask);
					failed = 1'b1;
				end
			end
		end
	end

	always @(negedge clk) begin
		if (arst_n) begin
			if (out_taken) begin
				out_taken = 1'b0;
				stall_left = $urandom_range(0, 16);
				if ($urandom_range(0, 3) == 0)
					stall_left = 0;
			end
			if (stall_left > 0) begin
				stall_left--;
				results.ready <= 1'b0;
			end else
				results.ready <= 1'b1;
		end
	end

	function automatic item_t random_frame(int ns, int nl);
		item_t it;
		it.kind = KIND_FRAME;
		it.fx25_busy = ($urandom_range(0, 5) == 0);
		if ($urandom_range(0, 9) == 0) begin
			it.subchan_index = 3'($urandom_range(0, 7));
			it.slice_index = 3'($urandom_range(0, 7));
		end else begin
			it.subchan_index = 3'($urandom_range(0, ns - 1));
			it.slice_index = 3'($urandom_range(0, nl - 1));
		end
		it.frame_handle = HANDLE_BITS'($urandom);
		it.frame_crc = ($urandom_range(0, 1) == 0) ? 16'(16'h5A5A + $urandom_range(0, 2))
			: 16'($urandom);
		it.audio_level = 24'($urandom);
		it.correction_count = 6'($urandom_range(0, 63));
		it.fec_kind = 2'($urandom_range(0, 3));
		return it;
	endfunction

	function automatic item_t tick_item(bit busy);
		item_t it;
		it = '0;
		it.kind = KIND_TICK;
		it.fx25_busy = busy;
		it.frame_handle = HANDLE_BITS'($urandom);
		it.audio_level = 24'($urandom);
		return it;
	endfunction

	task automatic settle();
		while (pending_items.size() > 0 || items.valid || expected_results.size() > 0)
			@(posedge clk);
		repeat (5000) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] value);
		@(negedge clk);
		cfg.index <= idx;
		cfg.wdata <= value;
		cfg.valid <= 1'b1;
		@(posedge clk);
		while (!cfg.ready)
			@(posedge clk);
		case (idx)
			REG_NUM_SUBCHAN: reg_ns = value[3:0];
			REG_NUM_SLICERS: reg_nl = value[3:0];
			REG_HOLD_TICKS: reg_hold = value[11:0];
			default: reg_ceiling = value[3:0];
		endcase
		@(negedge clk);
		cfg.valid <= 1'b0;
	endtask

	initial begin
		item_t it;
		int ns;
		int nl;
		items.valid = 1'b0;
		items.payload = '0;
		results.ready = 1'b0;
		cfg.valid = 1'b0;
		cfg.index = REG_NUM_SUBCHAN;
		cfg.wdata = '0;
		for (int i = 0; i < NSLOTS; i++) begin
			full_q[i] = 1'b0;
			age_q[i] = '0;
		end
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: pass-through extremes, then a small grid.
		it = '1;
		it.kind = KIND_FRAME;
		it.fx25_busy = 1'b0;
		it.fec_kind = 2'd2;
		pending_items.push_back(it);
		it = '0;
		it.kind = KIND_FRAME;
		pending_items.push_back(it);
		it.fx25_busy = 1'b1;
		it.frame_crc = 16'hFFFF;
		pending_items.push_back(it);
		pending_items.push_back(tick_item(1'b0));
		pending_items.push_back(tick_item(1'b0));
		settle();
		write_reg(REG_NUM_SUBCHAN, 2);
		write_reg(REG_NUM_SLICERS, 2);
		write_reg(REG_HOLD_TICKS, 0);
		write_reg(REG_RETRY_CEILING, 15);
		for (int i = 0; i < 4; i++) begin
			it = random_frame(2, 2);
			it.subchan_index = 3'(i % 2);
			it.slice_index = 3'(i / 2);
			it.frame_crc = 16'h1234;
			it.fec_kind = 2'(i % 4);
			it.correction_count = 6'((i == 3) ? 63 : i);
			pending_items.push_back(it);
		end
		it.subchan_index = 3'd7;
		pending_items.push_back(it);
		it.subchan_index = 3'd1;
		pending_items.push_back(it);
		pending_items.push_back(tick_item(1'b1));
		pending_items.push_back(tick_item(1'b0));
		settle();

		for (int phase = 0; phase < 9; phase++) begin
			case (phase)
				0: begin write_reg(REG_NUM_SUBCHAN, 8); write_reg(REG_NUM_SLICERS, 8);
					write_reg(REG_HOLD_TICKS, 3); write_reg(REG_RETRY_CEILING, 1); end
				1: begin write_reg(REG_NUM_SUBCHAN, 0); write_reg(REG_NUM_SLICERS, 15);
					write_reg(REG_HOLD_TICKS, 4095); end
				2: begin write_reg(REG_NUM_SUBCHAN, 1); write_reg(REG_NUM_SLICERS, 1); end
				default: begin
					write_reg(REG_NUM_SUBCHAN, $urandom_range(0, 15));
					write_reg(REG_NUM_SLICERS, $urandom_range(1, 4));
					write_reg(REG_HOLD_TICKS, $urandom_range(0, 6));
					write_reg(REG_RETRY_CEILING, $urandom_range(1, 15));
				end
			endcase
			ns = clamp_count(reg_ns, SUBCHAN_MAX);
			nl = clamp_count(reg_nl, SLICER_MAX);
			for (int i = 0; i < 200; i++) begin
				if ($urandom_range(0, 2) == 0)
					pending_items.push_back(tick_item($urandom_range(0, 7) == 0));
				else
					pending_items.push_back(random_frame(ns, nl));
				if (phase == 4 && i == 100) begin
					while (pending_items.size() > 0 || items.valid)
						@(posedge clk);
					hold_off = 1'b1;
					while (expected_results.size() > 0)
						@(posedge clk);
					hold_off = 1'b0;
				end
			end
			settle();
		end

		if (!failed)
			$display("multi_decoder_best_frame_picker_test OK");
		else
			$display("multi_decoder_best_frame_picker_test NOT OK");
		$finish;
	end

	initial begin
		#2000000000;
		$display("multi_decoder_best_frame_picker_test NOT OK");
		$finish;
	end

endmodule

@@ multi_decoder_best_frame_picker.f @@
hdl/mdbfp_pkg.sv
hdl/mdbfp_if.sv
hdl/mdbfp_cfg_regs.sv
hdl/multi_decoder_best_frame_picker.sv
bench/multi_decoder_best_frame_picker_test.sv
